// ===== src/srp_pkg.sv =====
package srp_pkg;

  localparam int STACK_DEPTH_DEF = 64;
  localparam int MAX_TAIL_DEF    = 4;
  localparam int NUM_RULES_DEF   = 6;
  localparam int MAX_REDUCE_DEF  = 32;

  localparam int SYM_W         = 8;
  localparam int LEN_W         = 3;
  localparam int TAIL_W        = 32;
  localparam int RULE_W        = SYM_W + LEN_W + TAIL_W;
  localparam int NUM_RULE_REGS = 6;
  localparam int RULE_IDX_W    = 3;
  localparam int OUT_DEPTH_W   = 7;

  // top-of-stack window held in flops
  localparam int WIN       = 4;
  localparam int WIN_W     = 3;
  localparam int WIN_IDX_W = 2;

  localparam int QUEUE_DEPTH = 2;

  localparam int CFG_ADDR_W = 3;
  localparam int CFG_DATA_W = RULE_W;

  localparam logic [CFG_ADDR_W-1:0] CFG_START      = 3'd0;
  localparam logic [CFG_ADDR_W-1:0] CFG_RULE_FIRST = 3'd1;
  localparam logic [CFG_ADDR_W-1:0] CFG_RULE_LAST  = 3'd6;

  typedef enum logic [2:0] {
    ACT_SHIFT    = 3'd0,
    ACT_REDUCE   = 3'd1,
    ACT_ACCEPT   = 3'd2,
    ACT_REJECT   = 3'd3,
    ACT_OVERFLOW = 3'd4,
    ACT_LIMIT    = 3'd5
  } action_t;

  typedef struct packed {
    logic             mode;
    logic [SYM_W-1:0] symbol;
    logic             last_symbol;
  } in_item_t;

  typedef struct packed {
    action_t                action;
    logic [RULE_IDX_W-1:0]  rule_used;
    logic [SYM_W-1:0]       pushed;
    logic [OUT_DEPTH_W-1:0] depth_after;
    logic                   end_of_run;
  } out_item_t;

  // classified item handed from front to back
  typedef struct packed {
    logic             is_shift;
    logic [SYM_W-1:0] symbol;
    logic             last_item;
  } cmd_t;

  typedef struct packed {
    logic [SYM_W-1:0]  head;
    logic [LEN_W-1:0]  len;
    logic [TAIL_W-1:0] tail;
  } rule_t;

  typedef struct packed {
    logic [SYM_W-1:0]                start_symbol;
    rule_t [NUM_RULE_REGS-1:0]       rules;
  } cfg_t;

  localparam logic [SYM_W-1:0] START_RESET = 8'd83;

  localparam rule_t [NUM_RULE_REGS-1:0] RULE_RESET = {
    43'd0,
    43'd0,
    43'd0,
    43'd2856153251937,
    43'd2864748636755,
    43'd2864748637011
  };

  function automatic out_item_t make_res(action_t act, logic [RULE_IDX_W-1:0] rule,
                                         logic [SYM_W-1:0] sym,
                                         logic [OUT_DEPTH_W-1:0] depth);
    out_item_t res;
    res.action      = act;
    res.rule_used   = rule;
    res.pushed      = sym;
    res.depth_after = depth;
    res.end_of_run  = 1'b0;
    return res;
  endfunction

endpackage

// ===== src/srp_ram.sv =====
module srp_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 64
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [WIDTH-1:0] rdata_r;

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata_r <= mem[raddr];
  end

  assign rdata = rdata_r;

endmodule

// ===== src/srp_front.sv =====
module srp_front
  import srp_pkg::*;
(
  input  logic     clk,
  input  logic     rst_n,
  input  logic     in_valid,
  input  in_item_t in_item,
  output logic     in_stall,
  output logic     q_valid,
  output cmd_t     q_cmd,
  input  logic     q_pop
);

  localparam int QPW = $clog2(QUEUE_DEPTH);
  localparam int CW  = $clog2(QUEUE_DEPTH + 1);

  cmd_t           fifo_r [QUEUE_DEPTH];
  logic [QPW-1:0] wr_ptr_r, wr_ptr_nxt;
  logic [QPW-1:0] rd_ptr_r, rd_ptr_nxt;
  logic [CW-1:0]  count_r, count_nxt;
  logic           push, pop;
  cmd_t           cmd;

  // end of input counts as a final item with nothing to shift
  always_comb begin
    cmd.is_shift  = !in_item.mode;
    cmd.symbol    = in_item.symbol;
    cmd.last_item = in_item.mode | in_item.last_symbol;
  end

  assign in_stall = (count_r == CW'(QUEUE_DEPTH));
  assign q_valid  = (count_r != '0);
  assign q_cmd    = fifo_r[rd_ptr_r];
  assign push     = in_valid && !in_stall;
  assign pop      = q_pop && q_valid;

  always_comb begin
    wr_ptr_nxt = wr_ptr_r;
    rd_ptr_nxt = rd_ptr_r;
    count_nxt  = count_r;
    if (push) begin
      wr_ptr_nxt = (wr_ptr_r == QPW'(QUEUE_DEPTH - 1)) ? '0 : wr_ptr_r + QPW'(1);
    end
    if (pop) begin
      rd_ptr_nxt = (rd_ptr_r == QPW'(QUEUE_DEPTH - 1)) ? '0 : rd_ptr_r + QPW'(1);
    end
    if (push && !pop) begin
      count_nxt = count_r + CW'(1);
    end else if (pop && !push) begin
      count_nxt = count_r - CW'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      count_r  <= count_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      fifo_r[wr_ptr_r] <= cmd;
    end
  end

endmodule

// ===== src/srp_back.sv =====
module srp_back
  import srp_pkg::*;
#(
  parameter int STACK_DEPTH = STACK_DEPTH_DEF,
  parameter int MAX_TAIL    = MAX_TAIL_DEF,
  parameter int NUM_RULES   = NUM_RULES_DEF,
  parameter int MAX_REDUCE  = MAX_REDUCE_DEF
) (
  input  logic      clk,
  input  logic      rst_n,
  input  cfg_t      cfg,
  input  logic      q_valid,
  input  cmd_t      q_cmd,
  output logic      q_pop,
  output logic      out_valid,
  output out_item_t out_item,
  input  logic      out_stall
);

  localparam int DW       = $clog2(STACK_DEPTH + 1);
  localparam int AW       = $clog2(STACK_DEPTH);
  localparam int RCW      = $clog2(MAX_REDUCE + 1);
  localparam int TAIL_LIM = (MAX_TAIL < WIN) ? MAX_TAIL : WIN;

  typedef enum logic [4:0] {
    ST_IDLE    = 5'b00001,
    ST_CHECK   = 5'b00010,
    ST_FILL_RD = 5'b00100,
    ST_FILL_WR = 5'b01000,
    ST_FLUSH   = 5'b10000
  } state_t;

  state_t                     state_r, state_nxt;
  logic [DW-1:0]              depth_r, depth_nxt;
  logic [WIN_W-1:0]           wcnt_r, wcnt_nxt;
  logic [WIN-1:0][SYM_W-1:0]  win_r, win_nxt;
  logic [RCW-1:0]             red_cnt_r, red_cnt_nxt;
  logic                       last_r, last_nxt;
  logic                       pend_valid_r, pend_valid_nxt;
  out_item_t                  pend_r, pend_nxt;
  logic                       out_valid_r, out_valid_nxt;
  out_item_t                  out_r, out_nxt;

  logic [NUM_RULE_REGS-1:0]   hit;
  logic                       found;
  logic [RULE_IDX_W-1:0]      m_idx;
  logic [WIN_W-1:0]           m_len;
  logic [SYM_W-1:0]           head;
  logic [WIN_W-1:0]           cap;
  logic [DW-1:0]              dep_red;
  logic [WIN_W-1:0]           wcnt_red;
  logic [WIN_W-1:0]           cap_red;
  logic [WIN_W-1:0]           wcnt_inc;
  logic                       accept_hit;
  logic                       emit_new;
  logic                       terminal;
  out_item_t                  res;
  logic                       out_free;
  logic                       ram_we;
  logic [AW-1:0]              spill_addr;
  logic [AW-1:0]              fill_addr;
  logic [SYM_W-1:0]           ram_rdata;
  logic [DW-1:0]              dep_spill;
  logic [DW-1:0]              dep_fill;

  // win_r[0] is the top of stack; entries below the window live in the RAM
  srp_ram #(
    .WIDTH(SYM_W),
    .DEPTH(STACK_DEPTH)
  ) u_stack (
    .clk  (clk),
    .we   (ram_we),
    .waddr(spill_addr),
    .wdata(win_r[WIN-1]),
    .raddr(fill_addr),
    .rdata(ram_rdata)
  );

  assign dep_spill  = depth_r - DW'(WIN);
  assign dep_fill   = depth_r - DW'(wcnt_r) - DW'(1);
  assign spill_addr = dep_spill[AW-1:0];
  assign fill_addr  = dep_fill[AW-1:0];

  function automatic logic tail_eq(rule_t rule, logic [WIN-1:0][SYM_W-1:0] w);
    logic ok;
    case (rule.len)
      3'd1: ok = rule.tail[7:0] == w[0];
      3'd2: ok = rule.tail[7:0] == w[1] && rule.tail[15:8] == w[0];
      3'd3: ok = rule.tail[7:0] == w[2] && rule.tail[15:8] == w[1] &&
                 rule.tail[23:16] == w[0];
      3'd4: ok = rule.tail[7:0] == w[3] && rule.tail[15:8] == w[2] &&
                 rule.tail[23:16] == w[1] && rule.tail[31:24] == w[0];
      default: ok = 1'b0;
    endcase
    return ok;
  endfunction

  // longest tail first, lowest rule index among equal lengths
  always_comb begin
    found = 1'b0;
    m_idx = '0;
    m_len = '0;
    for (int r = 0; r < NUM_RULE_REGS; r++) begin
      hit[r] = (r < NUM_RULES) && (cfg.rules[r].len != '0) &&
               (cfg.rules[r].len <= LEN_W'(TAIL_LIM)) &&
               (cfg.rules[r].len <= wcnt_r) && tail_eq(cfg.rules[r], win_r);
    end
    for (int l = WIN; l >= 1; l--) begin
      for (int r = 0; r < NUM_RULE_REGS; r++) begin
        if (!found && hit[r] && cfg.rules[r].len == LEN_W'(l)) begin
          found = 1'b1;
          m_idx = RULE_IDX_W'(r);
          m_len = WIN_W'(l);
        end
      end
    end
  end

  assign head     = cfg.rules[m_idx].head;
  assign cap      = (depth_r >= DW'(WIN)) ? WIN_W'(WIN) : WIN_W'(depth_r);
  assign dep_red  = depth_r - DW'(m_len) + DW'(1);
  assign wcnt_red = wcnt_r - m_len + WIN_W'(1);
  assign cap_red  = (dep_red >= DW'(WIN)) ? WIN_W'(WIN) : WIN_W'(dep_red);
  assign wcnt_inc = wcnt_r + WIN_W'(1);

  assign accept_hit = last_r && (depth_r == DW'(1)) && (win_r[0] == cfg.start_symbol);

  always_comb begin
    emit_new = 1'b1;
    terminal = 1'b0;
    res      = make_res(ACT_REDUCE, m_idx, head, OUT_DEPTH_W'(dep_red));
    if (accept_hit) begin
      terminal = 1'b1;
      res      = make_res(ACT_ACCEPT, '0, '0, '0);
    end else if (!found) begin
      if (last_r) begin
        terminal = 1'b1;
        res      = make_res(ACT_REJECT, '0, '0, '0);
      end else begin
        emit_new = 1'b0;
      end
    end else if (red_cnt_r == RCW'(MAX_REDUCE)) begin
      terminal = 1'b1;
      res      = make_res(ACT_LIMIT, '0, '0, '0);
    end
  end

  assign out_free = !out_valid_r || !out_stall;

  always_comb begin
    state_nxt      = state_r;
    depth_nxt      = depth_r;
    wcnt_nxt       = wcnt_r;
    win_nxt        = win_r;
    red_cnt_nxt    = red_cnt_r;
    last_nxt       = last_r;
    pend_valid_nxt = pend_valid_r;
    pend_nxt       = pend_r;
    out_valid_nxt  = out_valid_r && out_stall;
    out_nxt        = out_r;
    q_pop          = 1'b0;
    ram_we         = 1'b0;

    unique case (state_r)
      ST_IDLE: begin
        if (q_valid) begin
          q_pop       = 1'b1;
          red_cnt_nxt = '0;
          last_nxt    = q_cmd.last_item;
          if (q_cmd.is_shift) begin
            if (depth_r >= DW'(STACK_DEPTH)) begin
              pend_nxt       = make_res(ACT_OVERFLOW, '0, '0, '0);
              pend_valid_nxt = 1'b1;
              depth_nxt      = '0;
              wcnt_nxt       = '0;
              state_nxt      = ST_FLUSH;
            end else begin
              // spill the window bottom when the window is full
              ram_we         = (wcnt_r == WIN_W'(WIN));
              win_nxt        = {win_r[WIN-2:0], q_cmd.symbol};
              depth_nxt      = depth_r + DW'(1);
              wcnt_nxt       = (wcnt_r == WIN_W'(WIN)) ? wcnt_r : wcnt_inc;
              pend_nxt       = make_res(ACT_SHIFT, '0, q_cmd.symbol,
                                        OUT_DEPTH_W'(depth_r + DW'(1)));
              pend_valid_nxt = 1'b1;
              state_nxt      = ST_CHECK;
            end
          end else begin
            pend_valid_nxt = 1'b0;
            state_nxt      = ST_CHECK;
          end
        end
      end

      ST_CHECK: begin
        if (!pend_valid_r || out_free) begin
          if (pend_valid_r) begin
            out_valid_nxt      = 1'b1;
            out_nxt            = pend_r;
            out_nxt.end_of_run = !emit_new;
          end
          if (!emit_new) begin
            pend_valid_nxt = 1'b0;
            state_nxt      = ST_IDLE;
          end else if (terminal) begin
            pend_nxt       = res;
            pend_valid_nxt = 1'b1;
            depth_nxt      = '0;
            wcnt_nxt       = '0;
            state_nxt      = ST_FLUSH;
          end else begin
            win_nxt[0] = head;
            case (m_len)
              3'd2: begin
                win_nxt[1] = win_r[2];
                win_nxt[2] = win_r[3];
              end
              3'd3: win_nxt[1] = win_r[3];
              default: ;
            endcase
            depth_nxt      = dep_red;
            wcnt_nxt       = wcnt_red;
            red_cnt_nxt    = red_cnt_r + RCW'(1);
            pend_nxt       = res;
            pend_valid_nxt = 1'b1;
            state_nxt      = (wcnt_red < cap_red) ? ST_FILL_RD : ST_CHECK;
          end
        end
      end

      ST_FILL_RD: begin
        state_nxt = ST_FILL_WR;
      end

      ST_FILL_WR: begin
        win_nxt[wcnt_r[WIN_IDX_W-1:0]] = ram_rdata;
        wcnt_nxt  = wcnt_inc;
        state_nxt = (wcnt_inc < cap) ? ST_FILL_RD : ST_CHECK;
      end

      ST_FLUSH: begin
        if (out_free) begin
          out_valid_nxt      = 1'b1;
          out_nxt            = pend_r;
          out_nxt.end_of_run = 1'b1;
          pend_valid_nxt     = 1'b0;
          state_nxt          = ST_IDLE;
        end
      end

      default: state_nxt = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r      <= ST_IDLE;
      depth_r      <= '0;
      wcnt_r       <= '0;
      red_cnt_r    <= '0;
      last_r       <= 1'b0;
      pend_valid_r <= 1'b0;
      out_valid_r  <= 1'b0;
    end else begin
      state_r      <= state_nxt;
      depth_r      <= depth_nxt;
      wcnt_r       <= wcnt_nxt;
      red_cnt_r    <= red_cnt_nxt;
      last_r       <= last_nxt;
      pend_valid_r <= pend_valid_nxt;
      out_valid_r  <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    win_r  <= win_nxt;
    pend_r <= pend_nxt;
    out_r  <= out_nxt;
  end

  assign out_valid = out_valid_r;
  assign out_item  = out_r;

endmodule

// ===== src/shift_reduce_parser.sv =====
// Shift-reduce parser over a small grammar of up to six rules.
// Input channel (in_valid / in_stall / in_item): one symbol per transfer, or an
// end-of-input marker (mode 1). Result channel (out_valid / out_stall /
// out_item): every shift and reduction, then the verdict on a final item;
// end_of_run marks the last result of each input item.
// Configuration (cfg_we / cfg_addr / cfg_wdata): index 0 is the start symbol,
// indexes 1 to 6 the rule words. Write only while the parser is idle.
// With the back end idle, an accepted symbol passes from the queue into the
// pending register and then into the output register as its shift result. The
// back end takes the item in its idle state, then runs the rule compare on the
// top four symbols for each step (each reduction and the closing check), goes
// through a flush state for a verdict or error, and through a read state and a
// write state for every stack entry that is pulled back from the stack RAM after
// a reduction (one RAM read port). Items run through the back end one at a time.
// A two-entry queue in front takes items while the back end works.
// Reset clears the stack, the queue and the output valid flag, and loads the
// default grammar S->S+S, S->S*S, S->a with start symbol S.
// When the receiver stalls, the current result holds and the back end waits
// with its next result; the input side takes items until its queue is full.
module shift_reduce_parser
  import srp_pkg::*;
#(
  parameter int STACK_DEPTH = STACK_DEPTH_DEF,
  parameter int MAX_TAIL    = MAX_TAIL_DEF,
  parameter int NUM_RULES   = NUM_RULES_DEF,
  parameter int MAX_REDUCE  = MAX_REDUCE_DEF
) (
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  in_valid,
  input  in_item_t              in_item,
  output logic                  in_stall,
  output logic                  out_valid,
  output out_item_t             out_item,
  input  logic                  out_stall,
  input  logic                  cfg_we,
  input  logic [CFG_ADDR_W-1:0] cfg_addr,
  input  logic [CFG_DATA_W-1:0] cfg_wdata
);

  cfg_t                  cfg_r;
  logic [CFG_ADDR_W-1:0] rule_sel;
  logic                  q_valid;
  cmd_t                  q_cmd;
  logic                  q_pop;

  assign rule_sel = cfg_addr - CFG_RULE_FIRST;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.start_symbol <= START_RESET;
      cfg_r.rules        <= RULE_RESET;
    end else if (cfg_we) begin
      if (cfg_addr == CFG_START) begin
        cfg_r.start_symbol <= cfg_wdata[SYM_W-1:0];
      end else if (cfg_addr >= CFG_RULE_FIRST && cfg_addr <= CFG_RULE_LAST) begin
        cfg_r.rules[rule_sel] <= rule_t'(cfg_wdata);
      end
    end
  end

  srp_front u_front (
    .clk     (clk),
    .rst_n   (rst_n),
    .in_valid(in_valid),
    .in_item (in_item),
    .in_stall(in_stall),
    .q_valid (q_valid),
    .q_cmd   (q_cmd),
    .q_pop   (q_pop)
  );

  srp_back #(
    .STACK_DEPTH(STACK_DEPTH),
    .MAX_TAIL   (MAX_TAIL),
    .NUM_RULES  (NUM_RULES),
    .MAX_REDUCE (MAX_REDUCE)
  ) u_back (
    .clk      (clk),
    .rst_n    (rst_n),
    .cfg      (cfg_r),
    .q_valid  (q_valid),
    .q_cmd    (q_cmd),
    .q_pop    (q_pop),
    .out_valid(out_valid),
    .out_item (out_item),
    .out_stall(out_stall)
  );

endmodule

// ===== src/srp_checker.sv =====
module srp_checker
  import srp_pkg::*;
(
  input logic                  clk,
  input logic                  rst_n,
  input logic                  in_valid,
  input in_item_t              in_item,
  input logic                  in_stall,
  input logic                  out_valid,
  input out_item_t             out_item,
  input logic                  out_stall
);

  a_in_hold: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && in_stall |=> in_valid && $stable(in_item))
    else $error("input item changed while stalled");

  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_stall |=> out_valid && $stable(out_item))
    else $error("result changed while stalled");

  a_reset_clear: assert property (@(posedge clk)
    !rst_n |=> !out_valid && !in_stall)
    else $error("channels not cleared by reset");

  a_verdict_ends: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && (out_item.action == ACT_ACCEPT || out_item.action == ACT_REJECT ||
                  out_item.action == ACT_OVERFLOW || out_item.action == ACT_LIMIT)
    |-> out_item.depth_after == '0 && out_item.end_of_run && out_item.pushed == '0)
    else $error("verdict without cleared stack or end of run");

  a_rule_only_reduce: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_item.action != ACT_REDUCE |-> out_item.rule_used == '0)
    else $error("rule index on a non-reduce result");

endmodule

bind shift_reduce_parser srp_checker u_srp_checker (.*);
